FILE: rtl/core/life_generation_row_stencil_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Life row stencil
// Short forms for clocked assertions with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef LIFE_GENERATION_ROW_STENCIL_ASSERT_SVH
`define LIFE_GENERATION_ROW_STENCIL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LGRS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed in the Life row stencil");

// The consequent must hold in the cycle after the antecedent.
`define LGRS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed in the Life row stencil");

`endif

FILE: rtl/core/lgrs_pkg.sv
// ----------------------------------------------------------------------------
// lgrs_pkg
// Types, constants and the cell rule shared by the Life row stencil.
// ----------------------------------------------------------------------------
`default_nettype none

package lgrs_pkg;

    localparam int ROW_BITS          = 64;
    localparam int WIDTH_BITS        = 7;
    localparam int DEFAULT_MAX_WIDTH = 64;
    localparam int RESET_ROW_WIDTH   = 64;

    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    // One column as seen by its neighbors: the row above, the row itself, the row below.
    typedef struct packed {
        logic up;
        logic mid;
        logic down;
    } col_t;

    typedef struct packed {
        logic [ROW_BITS-1:0] next_row;
        logic                frame_done;
    } out_item_t;

    function automatic logic life_next(input logic alive, input logic [3:0] count);
        return (count == BIRTH_COUNT) || (alive && (count == SURVIVE_COUNT));
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/lgrs_cell.sv
// ----------------------------------------------------------------------------
// lgrs_cell
// One column of the stencil: holds the two previous rows of its column and
// computes the next state of the middle cell from its own and its neighbors'
// columns.
// ----------------------------------------------------------------------------
`default_nettype none

module lgrs_cell (
    input  wire logic         aclk,
    input  wire logic         load,
    input  wire logic         active,
    input  wire logic         in_bit,
    input  wire lgrs_pkg::col_t left_col,
    input  wire lgrs_pkg::col_t right_col,
    output lgrs_pkg::col_t    own_col,
    output logic              next_bit
);
    import lgrs_pkg::*;

    logic       upper_reg;
    logic       middle_reg;
    logic [3:0] count;

    // Stored bits are masked again here, since the width may have changed.
    assign own_col.up   = upper_reg & active;
    assign own_col.mid  = middle_reg & active;
    assign own_col.down = in_bit & active;

    assign count = {3'b000, left_col.up}  + {3'b000, left_col.mid}  + {3'b000, left_col.down}
                 + {3'b000, right_col.up} + {3'b000, right_col.mid} + {3'b000, right_col.down}
                 + {3'b000, own_col.up}   + {3'b000, own_col.down};

    assign next_bit = active & life_next(own_col.mid, count);

    always_ff @(posedge aclk) begin
        if (load) begin
            upper_reg  <= own_col.mid;
            middle_reg <= own_col.down;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/lgrs_out_skid.sv
// ----------------------------------------------------------------------------
// lgrs_out_skid
// Two-entry result holding stage: an output register plus a skid register,
// so the input side keeps moving while one result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module lgrs_out_skid (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire lgrs_pkg::out_item_t push_item,
    output logic                     can_accept,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output lgrs_pkg::out_item_t      m_item
);
    import lgrs_pkg::*;

    logic      out_valid_reg,  out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t out_item_reg,   out_item_next;
    out_item_t skid_item_reg,  skid_item_next;
    logic      pop;

    assign pop        = out_valid_reg && m_tready;
    assign can_accept = !skid_valid_reg;
    assign m_tvalid   = out_valid_reg;
    assign m_item     = out_item_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_item_next   = out_item_reg;
        skid_item_next  = skid_item_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                out_item_next   = skid_item_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
                out_item_next  = push_item;
            end
        end else if (push) begin
            if (!out_valid_reg) begin
                out_valid_next = 1'b1;
                out_item_next  = push_item;
            end else begin
                skid_valid_next = 1'b1;
                skid_item_next  = push_item;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_item_reg  <= out_item_next;
        skid_item_reg <= skid_item_next;
    end

endmodule

`default_nettype wire

FILE: rtl/core/life_generation_row_stencil.sv
// One generation of Life (birth on 3, survival on 2 or 3) over a frame streamed
// one row per item: the top halo row (tuser set), the body rows, and the bottom
// halo row (tlast set). Columns wrap at the configured row width; bits at and
// above it are ignored on input and are zero on output. From the third row of a
// frame on, each item yields the next state of the row before it, with tlast on
// the result of the bottom halo row. The block takes one item per clock with no
// gaps unless the slave stalls; a result is registered in the output stage before
// it reaches the master side. The slave side stalls only while two results wait.
// ----------------------------------------------------------------------------
// life_generation_row_stencil
// Top level: configuration, frame control, a chain of column cells and the
// output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module life_generation_row_stencil #(
    parameter int MAX_WIDTH = lgrs_pkg::DEFAULT_MAX_WIDTH
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [lgrs_pkg::WIDTH_BITS-1:0] cfg_wr_data,  // row_width
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [lgrs_pkg::ROW_BITS-1:0]   s_tdata,      // row_cells
    input  wire logic                            s_tuser,      // first_row
    input  wire logic                            s_tlast,      // last_row
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [lgrs_pkg::ROW_BITS-1:0]        m_tdata,      // next_row
    output logic                                 m_tlast       // frame_done
);
    import lgrs_pkg::*;

    localparam int COL_BITS    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RESET_WIDTH = (RESET_ROW_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_ROW_WIDTH;
    localparam logic [COL_BITS-1:0] RESET_LAST_COL = COL_BITS'(RESET_WIDTH - 1);
    localparam logic [WIDTH_BITS-1:0] MAX_WIDTH_W  = WIDTH_BITS'(MAX_WIDTH);

    logic [COL_BITS-1:0] last_col_reg;
    logic [COL_BITS-1:0] last_col_next;
    logic [1:0]          rows_seen_reg, rows_seen_next;
    logic [1:0]          rows_base;
    logic                s_accept;
    logic                produce;

    col_t                col     [MAX_WIDTH];
    col_t                left_in [MAX_WIDTH];
    col_t                right_in[MAX_WIDTH];
    logic [MAX_WIDTH-1:0] active;
    logic [MAX_WIDTH-1:0] next_bits;
    col_t                wrap_col;

    out_item_t           push_item;
    out_item_t           m_item;
    logic                can_accept;

    // Configuration: keep the index of the last column in use.
    always_comb begin
        if (cfg_wr_data == '0) begin
            last_col_next = '0;
        end else if (cfg_wr_data > MAX_WIDTH_W) begin
            last_col_next = COL_BITS'(MAX_WIDTH - 1);
        end else begin
            last_col_next = COL_BITS'(cfg_wr_data - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_col_reg <= RESET_LAST_COL;
        end else if (cfg_wr_en) begin
            last_col_reg <= last_col_next;
        end
    end

    // Frame control: a result needs two held rows of the current frame.
    assign s_tready  = can_accept;
    assign s_accept  = s_tvalid && s_tready;
    assign rows_base = s_tuser ? 2'd0 : rows_seen_reg;
    assign produce   = s_accept && (rows_base == 2'd2);

    always_comb begin
        rows_seen_next = rows_seen_reg;
        if (s_accept) begin
            if (s_tlast) begin
                rows_seen_next = 2'd0;
            end else if (rows_base == 2'd2) begin
                rows_seen_next = rows_base;
            end else begin
                rows_seen_next = rows_base + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_seen_reg <= 2'd0;
        end else begin
            rows_seen_reg <= rows_seen_next;
        end
    end

    // The leftmost cell wraps to the last column in use.
    assign wrap_col = col[last_col_reg];

    for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_cell
        assign active[c] = (COL_BITS'(c) <= last_col_reg);

        if (c == 0) begin : g_left_wrap
            assign left_in[c] = wrap_col;
        end else begin : g_left_chain
            assign left_in[c] = col[c-1];
        end

        if (c == MAX_WIDTH - 1) begin : g_right_wrap
            assign right_in[c] = col[0];
        end else begin : g_right_chain
            assign right_in[c] = (last_col_reg == COL_BITS'(c)) ? col[0] : col[c+1];
        end

        lgrs_cell u_cell (
            .aclk      (aclk),
            .load      (s_accept),
            .active    (active[c]),
            .in_bit    (s_tdata[c]),
            .left_col  (left_in[c]),
            .right_col (right_in[c]),
            .own_col   (col[c]),
            .next_bit  (next_bits[c])
        );
    end

    assign push_item.next_row   = ROW_BITS'(next_bits);
    assign push_item.frame_done = s_tlast;

    lgrs_out_skid u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (produce),
        .push_item  (push_item),
        .can_accept (can_accept),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_item     (m_item)
    );

    assign m_tdata = m_item.next_row;
    assign m_tlast = m_item.frame_done;

`include "life_generation_row_stencil_assert.svh"

    // A stalled input means both result registers are full.
    `LGRS_ASSERT_SAME(a_stall_needs_full, aclk, aresetn, !s_tready, m_tvalid)
    // The bottom halo row closes the frame.
    `LGRS_ASSERT_NEXT(a_last_closes, aclk, aresetn, s_accept && s_tlast, rows_seen_reg == 2'd0)
    // A top halo row never gives a result.
    `LGRS_ASSERT_NEXT(a_first_no_result, aclk, aresetn, s_accept && s_tuser && !m_tvalid,
                      !m_tvalid)

endmodule

`default_nettype wire
